/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, ignored while reset is held
`define PNE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Non-overlapping implication, ignored while reset is held
`define PNE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pne_pkg.sv */
// Shared types and constants of the picture nibble expander
package pne_pkg;

	localparam logic [7:0] BYTE_RUN_A = 8'hF0;
	localparam logic [7:0] BYTE_RUN_B = 8'hF2;
	localparam logic [7:0] BYTE_END   = 8'hFF;
	localparam logic [3:0] NIB_MASK   = 4'hF;
	localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

	// Results of one item: one or two bytes, the second always a lone nibble
	typedef struct packed {
		logic       pair;
		logic [7:0] byte0;
		logic       end0;
		logic [7:0] byte1;
	} rec_t;

endpackage

/* rtl/picture_nibble_expander.sv */
// The input takes one item per cycle while the result queue is not full.
// Results pass the queue and the output register; a pair holds the output for both.
// The input stalls only when the result queue (QUEUE_DEPTH items) is full.
// Reset clears the decode state and the queue and sets the length limit to 65535.
// Top level of the picture nibble expander
module picture_nibble_expander #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_in_run,
	output logic        image_end
);
	import pne_pkg::*;

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	rec_t push_rec;
	rec_t q_head;

	// Decode front end
	pne_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.q_full        (q_full),
		.push          (push),
		.push_rec      (push_rec)
	);

	// Result queue
	pne_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	// Output back end
	pne_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_in_run (last_in_run),
		.image_end   (image_end)
	);

endmodule

/* rtl/pne_front.sv */
// Front end: takes items, decodes the nibble stream and queues the results
module pne_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              end_of_stream,
	input  logic              q_full,
	output logic              push,
	output pne_pkg::rec_t     push_rec
);
	import pne_pkg::*;

	logic [15:0] limit_q;
	logic        misaligned_q;
	logic [3:0]  held_q;
	logic        expect_q;
	logic        term_q;
	logic [15:0] count_q;

	logic        nxt_mis;
	logic [3:0]  nxt_held;
	logic        nxt_exp;
	logic        nxt_term;
	logic [1:0]  cand;
	logic [1:0]  n_emit;
	logic [7:0]  full_v;
	logic [7:0]  r0;
	logic [7:0]  r1;
	logic        end0;
	logic        avail0;
	logic        avail1;
	logic        accept;
	logic [3:0]  hi;
	logic [3:0]  lo;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign hi       = in_byte[7:4];
	assign lo       = in_byte[3:0] & NIB_MASK;
	assign full_v   = misaligned_q ? {held_q, hi} : in_byte;
	assign avail0   = count_q < limit_q;
	assign avail1   = ({1'b0, count_q} + 17'd1) < {1'b0, limit_q};

	// Decode one byte into candidate results and next state
	always_comb begin
		nxt_mis  = misaligned_q;
		nxt_held = held_q;
		nxt_exp  = expect_q;
		nxt_term = term_q;
		cand     = 2'd0;
		r0       = 8'h00;
		r1       = 8'h00;
		end0     = 1'b0;
		if (!term_q) begin
			if (expect_q) begin
				cand     = 2'd1;
				r0       = {4'h0, hi};
				nxt_exp  = 1'b0;
				nxt_mis  = 1'b1;
				nxt_held = lo;
			end else begin
				cand = 2'd1;
				r0   = full_v;
				if (misaligned_q) begin
					nxt_held = lo;
				end
				if (full_v == BYTE_END) begin
					end0     = 1'b1;
					nxt_term = 1'b1;
				end else if (full_v == BYTE_RUN_A || full_v == BYTE_RUN_B) begin
					if (misaligned_q) begin
						cand     = 2'd2;
						r1       = {4'h0, lo};
						nxt_mis  = 1'b0;
						nxt_held = 4'h0;
					end else begin
						nxt_exp = 1'b1;
					end
				end
			end
		end
	end

	// Trim the results to what the length limit still allows
	always_comb begin
		priority if (cand == 2'd0 || !avail0) begin
			n_emit = 2'd0;
		end else if (cand == 2'd1 || !avail1) begin
			n_emit = 2'd1;
		end else begin
			n_emit = 2'd2;
		end
	end

	assign push           = accept && (n_emit != 2'd0);
	assign push_rec.pair  = (n_emit == 2'd2);
	assign push_rec.byte0 = r0;
	assign push_rec.end0  = end0;
	assign push_rec.byte1 = r1;

	// Hold the length limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Advance the decode state; clear it after the last byte of a stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			misaligned_q <= 1'b0;
			held_q       <= 4'h0;
			expect_q     <= 1'b0;
			term_q       <= 1'b0;
			count_q      <= 16'd0;
		end else if (accept) begin
			if (end_of_stream) begin
				misaligned_q <= 1'b0;
				held_q       <= 4'h0;
				expect_q     <= 1'b0;
				term_q       <= 1'b0;
				count_q      <= 16'd0;
			end else begin
				misaligned_q <= nxt_mis;
				held_q       <= nxt_held;
				expect_q     <= nxt_exp;
				term_q       <= nxt_term;
				count_q      <= count_q + {14'd0, n_emit};
			end
		end
	end

endmodule

/* rtl/pne_queue.sv */
// Short result queue between the decoder and the output stage
module pne_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pne_pkg::rec_t push_rec,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output pne_pkg::rec_t head
);
	import pne_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	rec_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/pne_back.sv */
// Back end: unrolls queued items into single result bytes on the output
module pne_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  pne_pkg::rec_t q_head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          last_in_run,
	output logic          image_end
);
	import pne_pkg::*;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       end_q;
	logic       sec_valid_q;
	logic [7:0] sec_byte_q;
	logic       load_ok;

	assign load_ok     = !out_valid_q || !out_stall;
	assign pop         = load_ok && !sec_valid_q && !q_empty;
	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_in_run = last_q;
	assign image_end   = end_q;

	// Load the output register from the pending nibble or the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (load_ok) begin
			if (sec_valid_q) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b0;
			end else begin
				out_valid_q <= !q_empty;
				sec_valid_q <= !q_empty && q_head.pair;
			end
		end
	end

	// Payload of the output register and the pending second result
	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (sec_valid_q) begin
				out_byte_q <= sec_byte_q;
				last_q     <= 1'b1;
				end_q      <= 1'b0;
			end else if (!q_empty) begin
				out_byte_q <= q_head.byte0;
				last_q     <= !q_head.pair;
				end_q      <= q_head.end0;
				sec_byte_q <= q_head.byte1;
			end
		end
	end

endmodule

/* rtl/pne_checker.sv */
// Port-level checks of the picture nibble expander and their binding
`include "assert_macros.svh"

module pne_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last_in_run,
	input logic       image_end
);
	import pne_pkg::*;

	// A stalled result holds its byte
	`PNE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte), "stalled result changed")

	// The terminator is always the byte 0xFF and closes its item
	`PNE_ASSERT_IMPL(a_end_byte, out_valid && image_end, out_byte == BYTE_END && last_in_run, "image end on wrong byte")

	// Only a run marker can be followed by a second result of the same item
	`PNE_ASSERT_IMPL(a_pair_head, out_valid && !last_in_run, out_byte == BYTE_RUN_A || out_byte == BYTE_RUN_B, "pair without run marker")

	// The second result of a pair follows at once
	`PNE_ASSERT_NEXT(a_pair_next, out_valid && !out_stall && !last_in_run, out_valid && last_in_run, "second result of pair missing")

endmodule

bind picture_nibble_expander pne_checker u_pne_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.last_in_run (last_in_run),
	.image_end   (image_end)
);
